// File: src/pkdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pkdb_pkg;

   localparam int NUM_LINES_DEF  = 10;
   localparam int RUN_WIDTH_DEF  = 8;
   localparam int MAX_LINES      = 16;
   localparam int ROW_W          = 4;
   localparam int LINES_W        = 10;
   localparam int CODE_W         = 5;
   localparam int COUNT_W        = 6;
   localparam int DEBOUNCE_W     = 8;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd2;
   localparam logic [COUNT_W-1:0]    TALLY_MAX      = 6'd63;
   localparam logic [COUNT_W-1:0]    GHOST_RAISE    = 6'd3;
   localparam logic [COUNT_W-1:0]    GHOST_REARM    = 6'd2;

   localparam logic REC_KEY     = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   // one processed row, handed from the pair state to the result queue
   typedef struct packed {
      logic [MAX_LINES-1:0] event_mask;
      logic [MAX_LINES-1:0] raw;
      logic [ROW_W-1:0]     row;
      logic                 summary;
      logic [COUNT_W-1:0]   count;
      logic                 warn;
   } pkdb_batch_type;

   typedef struct packed {
      logic               record_kind;
      logic [CODE_W-1:0]  key_code;
      logic               pressed;
      logic [ROW_W-1:0]   line_low;
      logic [ROW_W-1:0]   line_high;
      logic [COUNT_W-1:0] pressed_count;
      logic               ghost_warning;
      logic               last;
   } pkdb_result_type;

   function automatic logic [CODE_W-1:0] key_code_of(input logic [ROW_W-1:0] lo,
                                                     input logic [ROW_W-1:0] hi);
      logic [CODE_W-1:0] code;
      case ({lo, hi})
         8'h08: code = 5'd6;
         8'h12: code = 5'd12;
         8'h13: code = 5'd11;
         8'h14: code = 5'd9;
         8'h15: code = 5'd8;
         8'h16: code = 5'd7;
         8'h17: code = 5'd1;
         8'h18: code = 5'd2;
         8'h19: code = 5'd3;
         8'h23: code = 5'd27;
         8'h24: code = 5'd26;
         8'h25: code = 5'd4;
         8'h26: code = 5'd24;
         8'h27: code = 5'd19;
         8'h28: code = 5'd14;
         8'h29: code = 5'd5;
         8'h35: code = 5'd15;
         8'h36: code = 5'd25;
         8'h38: code = 5'd10;
         8'h45: code = 5'd20;
         8'h46: code = 5'd21;
         8'h48: code = 5'd22;
         8'h49: code = 5'd23;
         8'h56: code = 5'd18;
         8'h57: code = 5'd17;
         8'h58: code = 5'd16;
         8'h59: code = 5'd13;
         default: code = '0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: src/pkdb_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface pkdb_req_if import pkdb_pkg::*;;
   logic               valid;
   logic               ready;
   logic [ROW_W-1:0]   row;
   logic [LINES_W-1:0] lines;

   modport source (output valid, row, lines, input ready);
   modport sink   (input valid, row, lines, output ready);
endinterface

interface pkdb_rsp_if import pkdb_pkg::*;;
   logic               valid;
   logic               ready;
   logic               record_kind;
   logic [CODE_W-1:0]  key_code;
   logic               pressed;
   logic [ROW_W-1:0]   line_low;
   logic [ROW_W-1:0]   line_high;
   logic [COUNT_W-1:0] pressed_count;
   logic               ghost_warning;
   logic               last;

   modport source (output valid, record_kind, key_code, pressed, line_low, line_high,
                   pressed_count, ghost_warning, last, input ready);
   modport sink   (input valid, record_kind, key_code, pressed, line_low, line_high,
                   pressed_count, ghost_warning, last, output ready);
endinterface

interface pkdb_csr_if import pkdb_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [DEBOUNCE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: src/pair_keypad_scan_debounce_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                        transaction
// req_chan  in   row[3:0], lines[9:0]                           one scan row
// rsp_chan  out  record_kind, key_code, pressed, line_low/high,  one event or summary
//                pressed_count, ghost_warning, last
// csr_chan  in   data[7:0]                                      debounce length write
//
// A row is registered, then its pair state is read, updated and written back while
// its events move into a result buffer; the buffer drains one result per cycle into
// the output register while rsp_chan does not stall it. A row with k results (0 to 9
// with ten lines, row 0 having nine pairs) holds the buffer until its last result
// drains, and the next row is taken as that last result leaves.
// Reset clears all pair state, the tally and the warning flag.
// A stalled rsp_chan backs up into the buffer, then the input register, then req_chan.

module pair_keypad_scan_debounce_top import pkdb_pkg::*; #(
   parameter int NUM_LINES = NUM_LINES_DEF,
   parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   pkdb_req_if.sink    req_chan,
   pkdb_rsp_if.source  rsp_chan,
   pkdb_csr_if.sink    csr_chan
);

   logic                  in_valid_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [LINES_W-1:0]    lines_ff;
   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic                  buf_free;
   logic                  process;
   pkdb_batch_type        batch;

   assign process        = in_valid_ff && buf_free;
   assign req_chan.ready = !in_valid_ff || process;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         row_ff   <= req_chan.row;
         lines_ff <= req_chan.lines;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         debounce_ff <= csr_chan.data;
      end
   end

   pkdb_pair_update #(
      .NUM_LINES (NUM_LINES),
      .RUN_WIDTH (RUN_WIDTH)
   ) u_pair_update (
      .clock        (clock),
      .reset        (reset),
      .update       (process),
      .row          (row_ff),
      .lines        (lines_ff),
      .stable_scans (debounce_ff),
      .batch        (batch)
   );

   pkdb_result_queue u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (process),
      .batch    (batch),
      .buf_free (buf_free),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

// File: src/pkdb_pair_update.sv
`timescale 1ns / 1ps
`default_nettype none

module pkdb_pair_update import pkdb_pkg::*; #(
   parameter int NUM_LINES = NUM_LINES_DEF,
   parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  update,
   input  wire logic [ROW_W-1:0]      row,
   input  wire logic [LINES_W-1:0]    lines,
   input  wire logic [DEBOUNCE_W-1:0] stable_scans,
   output pkdb_batch_type             batch
);

   localparam int RIDX_W = $clog2(NUM_LINES);
   localparam int CMP_W  = (RUN_WIDTH > DEBOUNCE_W) ? RUN_WIDTH : DEBOUNCE_W;
   localparam int CNT_W  = $clog2(NUM_LINES + 1);
   localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

   logic [NUM_LINES-1:0] stable_ff [NUM_LINES];
   logic [NUM_LINES-1:0] prev_ff   [NUM_LINES];
   logic [RUN_WIDTH-1:0] run_ff    [NUM_LINES][NUM_LINES];
   logic [COUNT_W-1:0]   tally_ff;
   logic                 armed_off_ff;

   logic                 row_ok;
   logic [RIDX_W-1:0]    ridx;
   logic [MAX_LINES-1:0] lines_ext;
   logic [NUM_LINES-1:0] active;
   logic [NUM_LINES-1:0] raw;
   logic [NUM_LINES-1:0] evt;
   logic [RUN_WIDTH-1:0] run_in [NUM_LINES];
   logic [CNT_W-1:0]     row_count;
   logic [COUNT_W:0]     tally_sum;
   logic [COUNT_W-1:0]   tally_in;
   logic                 summary;
   logic                 warn;

   always_comb begin
      row_ok    = {1'b0, row} < (ROW_W+1)'(NUM_LINES);
      ridx      = row[RIDX_W-1:0];
      lines_ext = {{(MAX_LINES-LINES_W){1'b0}}, lines};
      for (int j = 0; j < NUM_LINES; j++) begin
         active[j] = row_ok && ((ROW_W+1)'(j) > {1'b0, row});
         raw[j]    = ~lines_ext[j];
         if (raw[j] == prev_ff[ridx][j]) begin
            run_in[j] = (run_ff[ridx][j] == RUN_MAX) ? RUN_MAX
                                                     : run_ff[ridx][j] + 1'b1;
         end else begin
            run_in[j] = RUN_WIDTH'(1);
         end
         evt[j] = active[j] && (CMP_W'(run_in[j]) >= CMP_W'(stable_scans))
                  && (stable_ff[ridx][j] != raw[j]);
      end
      row_count = CNT_W'($countones(raw & active));
      tally_sum = {1'b0, tally_ff} + (COUNT_W+1)'(row_count);
      tally_in  = (tally_sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : tally_sum[COUNT_W-1:0];
      summary   = row_ok && (row == ROW_W'(NUM_LINES - 1));
      warn      = summary && (tally_in >= GHOST_RAISE) && !armed_off_ff;

      batch            = '0;
      batch.event_mask = MAX_LINES'(evt);
      batch.raw        = MAX_LINES'(raw);
      batch.row        = row;
      batch.summary    = summary;
      batch.count      = summary ? tally_in : '0;
      batch.warn       = warn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_LINES; r++) begin
            stable_ff[r] <= '0;
            prev_ff[r]   <= '0;
            for (int j = 0; j < NUM_LINES; j++) begin
               run_ff[r][j] <= '0;
            end
         end
         tally_ff     <= '0;
         armed_off_ff <= 1'b0;
      end else if (update) begin
         for (int j = 0; j < NUM_LINES; j++) begin
            if (active[j]) begin
               run_ff[ridx][j]  <= run_in[j];
               prev_ff[ridx][j] <= raw[j];
               if (evt[j]) begin
                  stable_ff[ridx][j] <= raw[j];
               end
            end
         end
         if (summary) begin
            tally_ff <= '0;
            if (tally_in < GHOST_REARM) begin
               armed_off_ff <= 1'b0;
            end else if (warn) begin
               armed_off_ff <= 1'b1;
            end
         end else begin
            tally_ff <= tally_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: src/pkdb_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pkdb_result_queue import pkdb_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire pkdb_batch_type batch,
   output logic                buf_free,
   pkdb_rsp_if.source          rsp
);

   pkdb_batch_type       batch_ff;
   logic [MAX_LINES-1:0] pend_ff;
   logic                 sum_pend_ff;
   logic                 out_valid_ff;
   pkdb_result_type      out_ff;

   logic                 buf_empty;
   logic                 out_free;
   logic                 emit;
   logic                 have_evt;
   logic [MAX_LINES-1:0] sel_oh;
   logic [MAX_LINES-1:0] rest;
   logic [ROW_W-1:0]     sel_idx;
   logic                 emit_last;
   pkdb_result_type      out_in;

   always_comb begin
      buf_empty = (pend_ff == '0) && !sum_pend_ff;
      out_free  = !out_valid_ff || rsp.ready;
      emit      = !buf_empty && out_free;
      have_evt  = |pend_ff;
      sel_oh    = pend_ff & (~pend_ff + 1'b1);
      rest      = pend_ff & ~sel_oh;
      sel_idx   = '0;
      for (int j = MAX_LINES - 1; j >= 0; j--) begin
         if (pend_ff[j]) begin
            sel_idx = ROW_W'(j);
         end
      end
      emit_last = have_evt ? ((rest == '0) && !sum_pend_ff) : 1'b1;
      buf_free  = buf_empty || (emit && emit_last);

      out_in = '0;
      if (have_evt) begin
         out_in.record_kind = REC_KEY;
         out_in.key_code    = key_code_of(batch_ff.row, sel_idx);
         out_in.pressed     = batch_ff.raw[sel_idx];
         out_in.line_low    = batch_ff.row;
         out_in.line_high   = sel_idx;
      end else begin
         out_in.record_kind   = REC_SUMMARY;
         out_in.pressed_count = batch_ff.count;
         out_in.ghost_warning = batch_ff.warn;
      end
      out_in.last = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         sum_pend_ff <= 1'b0;
      end else if (load) begin
         pend_ff     <= batch.event_mask;
         sum_pend_ff <= batch.summary;
      end else if (emit) begin
         if (have_evt) begin
            pend_ff <= rest;
         end else begin
            sum_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         batch_ff <= batch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.record_kind   = out_ff.record_kind;
   assign rsp.key_code      = out_ff.key_code;
   assign rsp.pressed       = out_ff.pressed;
   assign rsp.line_low      = out_ff.line_low;
   assign rsp.line_high     = out_ff.line_high;
   assign rsp.pressed_count = out_ff.pressed_count;
   assign rsp.ghost_warning = out_ff.ghost_warning;
   assign rsp.last          = out_ff.last;

endmodule

`default_nettype wire

// File: src/pkdb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pkdb_checker import pkdb_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_record_kind,
   input wire logic [ROW_W-1:0]   rsp_line_low,
   input wire logic [ROW_W-1:0]   rsp_line_high,
   input wire logic [COUNT_W-1:0] rsp_pressed_count,
   input wire logic               rsp_ghost_warning,
   input wire logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == REC_KEY) |-> rsp_line_low < rsp_line_high)
      else $error("key event with lower line not below higher line");

   a_ghost_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ghost_warning |->
         (rsp_record_kind == REC_SUMMARY) && (rsp_pressed_count >= GHOST_RAISE))
      else $error("ghost warning without a summary of three or more pairs");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == REC_SUMMARY) |-> rsp_last)
      else $error("summary not marked last");

endmodule

bind pair_keypad_scan_debounce_top pkdb_checker u_pkdb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_record_kind   (rsp_chan.record_kind),
   .rsp_line_low      (rsp_chan.line_low),
   .rsp_line_high     (rsp_chan.line_high),
   .rsp_pressed_count (rsp_chan.pressed_count),
   .rsp_ghost_warning (rsp_chan.ghost_warning),
   .rsp_last          (rsp_chan.last)
);

`default_nettype wire
